### rtl/pwb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Perspective warp package
// Widths, codes and item types that the warp modules share.
// ----------------------------------------------------------------------------
package pwb_pkg;

   localparam int SrcWidthDefault  = 256;
   localparam int SrcHeightDefault = 256;

   localparam int CoefW   = 32;
   localparam int NumCoef = 8;
   localparam int PosW    = 12;
   localparam int ChanW   = 8;
   localparam int FracW   = 8;
   localparam int QuotW   = PosW + FracW;
   localparam int ProdW   = CoefW + PosW + 1;
   localparam int SumW    = ProdW + 2;
   localparam int DenW    = SumW;
   localparam int RemW    = DenW + QuotW;
   localparam int WeightW = 2 * FracW + 1;
   localparam int TermW   = ChanW + WeightW;
   localparam int AccW    = TermW + 2;

   localparam logic signed [CoefW-1:0] OneQ16 = 32'sd65536;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      REG_COEF_A,
      REG_COEF_B,
      REG_COEF_C,
      REG_COEF_D,
      REG_COEF_E,
      REG_COEF_F,
      REG_COEF_G,
      REG_COEF_H
   } reg_type;

   typedef logic [NumCoef-1:0][CoefW-1:0] coef_set_type;

   localparam coef_set_type CoefReset = {
      32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd65536
   };

   typedef struct packed {
      logic [ChanW-1:0] red;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] blue;
   } pixel_type;

   typedef struct packed {
      op_type          op;
      logic [PosW-1:0] col;
      logic [PosW-1:0] row;
      pixel_type       pix;
   } item_type;

   typedef struct packed {
      item_type         item;
      logic             outside;
      logic [RemW-1:0]  rem_x;
      logic [RemW-1:0]  rem_y;
      logic [DenW-1:0]  den;
      logic [QuotW-1:0] quot_x;
      logic [QuotW-1:0] quot_y;
   } div_type;

   typedef struct packed {
      item_type  item;
      logic      outside;
      pixel_type pix;
   } result_type;

endpackage
`default_nettype wire

### rtl/pwb_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Perspective warp channels
// Request and response channels with valid, ready and payload.
// ----------------------------------------------------------------------------
interface pwb_req_if;
   logic                      valid;
   logic                      ready;
   logic                      op;
   logic [pwb_pkg::PosW-1:0]  col;
   logic [pwb_pkg::PosW-1:0]  row;
   logic [pwb_pkg::ChanW-1:0] red;
   logic [pwb_pkg::ChanW-1:0] green;
   logic [pwb_pkg::ChanW-1:0] blue;

   modport source (output valid, op, col, row, red, green, blue, input ready);
   modport sink (input valid, op, col, row, red, green, blue, output ready);
endinterface

interface pwb_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [pwb_pkg::PosW-1:0]  out_col;
   logic [pwb_pkg::PosW-1:0]  out_row;
   logic [pwb_pkg::ChanW-1:0] out_red;
   logic [pwb_pkg::ChanW-1:0] out_green;
   logic [pwb_pkg::ChanW-1:0] out_blue;
   logic                      outside;

   modport source (output valid, out_col, out_row, out_red, out_green, out_blue,
                   outside, input ready);
   modport sink (input valid, out_col, out_row, out_red, out_green, out_blue,
                 outside, output ready);
endinterface
`default_nettype wire

### rtl/pwb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pwb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/pwb_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Homography mapping front end
// Four stages: products, sums, magnitudes, range checks for the divider.
// ----------------------------------------------------------------------------
module pwb_map #(
   parameter int QUOT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pwb_pkg::coef_set_type coef,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  pwb_pkg::item_type     in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output pwb_pkg::div_type      out_data
);

   localparam int Stages = 4;
   localparam int CoefW  = pwb_pkg::CoefW;
   localparam int PosW   = pwb_pkg::PosW;
   localparam int ProdW  = pwb_pkg::ProdW;
   localparam int SumW   = pwb_pkg::SumW;
   localparam int DenW   = pwb_pkg::DenW;
   localparam int RemW   = pwb_pkg::RemW;

   logic [Stages-1:0] valid_ff;
   logic [Stages-1:0] valid_in;
   logic [Stages-1:0] stage_en;

   logic signed [CoefW-1:0] coef_s [pwb_pkg::NumCoef];
   logic signed [PosW:0]    col_s;
   logic signed [PosW:0]    row_s;

   pwb_pkg::item_type item_ff [Stages-1];
   logic signed [ProdW-1:0] prod_ff [6];
   logic signed [ProdW-1:0] prod_in [6];
   logic signed [SumW-1:0]  x_ff, y_ff, w_ff;
   logic signed [SumW-1:0]  x_in, y_in, w_in;
   logic [SumW-1:0]         x_abs, y_abs, w_abs;
   logic [RemW-1:0]         nx_ff, ny_ff, nx_in, ny_in;
   logic [DenW-1:0]         den_ff, den_in;
   logic                    zero_ff, negx_ff, negy_ff;
   logic                    zero_in, negx_in, negy_in;
   logic [RemW-1:0]         limit;
   pwb_pkg::div_type        out_ff, out_in;

   always_comb begin
      stage_en[Stages-1] = !valid_ff[Stages-1] || out_ready;
      for (int k = Stages - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in = {valid_ff[Stages-2:0], in_valid};
   end

   always_comb begin
      for (int k = 0; k < pwb_pkg::NumCoef; k++) begin
         coef_s[k] = coef[k];
      end
      col_s = {1'b0, in_item.col};
      row_s = {1'b0, in_item.row};
      prod_in[0] = coef_s[pwb_pkg::REG_COEF_A] * col_s;
      prod_in[1] = coef_s[pwb_pkg::REG_COEF_B] * row_s;
      prod_in[2] = coef_s[pwb_pkg::REG_COEF_D] * col_s;
      prod_in[3] = coef_s[pwb_pkg::REG_COEF_E] * row_s;
      prod_in[4] = coef_s[pwb_pkg::REG_COEF_G] * col_s;
      prod_in[5] = coef_s[pwb_pkg::REG_COEF_H] * row_s;
   end

   always_comb begin
      x_in = SumW'(prod_ff[0]) + SumW'(prod_ff[1]) + SumW'(coef_s[pwb_pkg::REG_COEF_C]);
      y_in = SumW'(prod_ff[2]) + SumW'(prod_ff[3]) + SumW'(coef_s[pwb_pkg::REG_COEF_F]);
      w_in = SumW'(prod_ff[4]) + SumW'(prod_ff[5]) + SumW'(pwb_pkg::OneQ16);
   end

   always_comb begin
      x_abs   = x_ff[SumW-1] ? -x_ff : x_ff;
      y_abs   = y_ff[SumW-1] ? -y_ff : y_ff;
      w_abs   = w_ff[SumW-1] ? -w_ff : w_ff;
      nx_in   = RemW'(x_abs) << pwb_pkg::FracW;
      ny_in   = RemW'(y_abs) << pwb_pkg::FracW;
      den_in  = DenW'(w_abs);
      zero_in = (w_ff == '0);
      negx_in = (x_ff != '0) && (x_ff[SumW-1] != w_ff[SumW-1]);
      negy_in = (y_ff != '0) && (y_ff[SumW-1] != w_ff[SumW-1]);
   end

   always_comb begin
      limit          = RemW'(den_ff) << QUOT_BITS;
      out_in.item    = item_ff[2];
      out_in.outside = zero_ff || negx_ff || negy_ff || (nx_ff >= limit) || (ny_ff >= limit);
      out_in.rem_x   = nx_ff;
      out_in.rem_y   = ny_ff;
      out_in.den     = den_ff;
      out_in.quot_x  = '0;
      out_in.quot_y  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < Stages; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         item_ff[0] <= in_item;
         prod_ff    <= prod_in;
      end
      if (stage_en[1]) begin
         item_ff[1] <= item_ff[0];
         x_ff       <= x_in;
         y_ff       <= y_in;
         w_ff       <= w_in;
      end
      if (stage_en[2]) begin
         item_ff[2] <= item_ff[1];
         nx_ff      <= nx_in;
         ny_ff      <= ny_in;
         den_ff     <= den_in;
         zero_ff    <= zero_in;
         negx_ff    <= negx_in;
         negy_ff    <= negy_in;
      end
      if (stage_en[3]) begin
         out_ff <= out_in;
      end
   end

   assign in_ready  = stage_en[0];
   assign out_valid = valid_ff[Stages-1];
   assign out_data  = out_ff;

endmodule
`default_nettype wire

### rtl/pwb_div_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Divider stage
// One restoring quotient bit for both source axes, with its own register.
// ----------------------------------------------------------------------------
module pwb_div_stage #(
   parameter int SHIFT = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  pwb_pkg::div_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output pwb_pkg::div_type out_data
);

   logic                     valid_ff;
   logic                     stage_en;
   logic [pwb_pkg::RemW-1:0] trial;
   pwb_pkg::div_type         data_ff, data_in;

   assign stage_en = !valid_ff || out_ready;

   always_comb begin
      trial   = pwb_pkg::RemW'(in_data.den) << SHIFT;
      data_in = in_data;
      if (in_data.rem_x >= trial) begin
         data_in.rem_x         = in_data.rem_x - trial;
         data_in.quot_x[SHIFT] = 1'b1;
      end
      if (in_data.rem_y >= trial) begin
         data_in.rem_y         = in_data.rem_y - trial;
         data_in.quot_y[SHIFT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         data_ff <= data_in;
      end
   end

   assign in_ready  = stage_en;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

### rtl/pwb_sampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear sampler
// Range check, four-bank image store, weighted products and final blend.
// ----------------------------------------------------------------------------
module pwb_sampler #(
   parameter int SRC_WIDTH  = pwb_pkg::SrcWidthDefault,
   parameter int SRC_HEIGHT = pwb_pkg::SrcHeightDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  pwb_pkg::div_type    in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output pwb_pkg::result_type out_data
);

   localparam int Stages    = 4;
   localparam int PosW      = pwb_pkg::PosW;
   localparam int FracW     = pwb_pkg::FracW;
   localparam int FracOneW  = FracW + 1;
   localparam int ChanW     = pwb_pkg::ChanW;
   localparam int QuotW     = pwb_pkg::QuotW;
   localparam int WeightW   = pwb_pkg::WeightW;
   localparam int TermW     = pwb_pkg::TermW;
   localparam int AccW      = pwb_pkg::AccW;
   localparam int PixW      = $bits(pwb_pkg::pixel_type);
   localparam int HalfW     = (SRC_WIDTH + 1) / 2;
   localparam int HalfH     = (SRC_HEIGHT + 1) / 2;
   localparam int BankDepth = HalfW * HalfH;
   localparam int AddrW     = (BankDepth > 1) ? $clog2(BankDepth) : 1;
   localparam int LimitX    = (SRC_WIDTH - 1) * (1 << FracW);
   localparam int LimitY    = (SRC_HEIGHT - 1) * (1 << FracW);

   logic [Stages-1:0] valid_ff;
   logic [Stages-1:0] valid_in;
   logic [Stages-1:0] stage_en;

   // Address stage.
   pwb_pkg::item_type item0_ff;
   logic              out0_ff, out0_in;
   logic [PosW-1:0]   x0_ff, x1_ff, y0_ff, y1_ff;
   logic [PosW-1:0]   x0_in, x1_in, y0_in, y1_in;
   logic [FracW-1:0]  fx_ff, fy_ff;

   // Store read stage.
   pwb_pkg::item_type  item1_ff;
   logic               out1_ff;
   logic [WeightW-1:0] weight_ff [4];
   logic [WeightW-1:0] weight_in [4];
   logic [1:0]         sel_ff [4];
   logic [1:0]         sel_in [4];
   logic [FracW:0]     wx0, wx1, wy0, wy1;
   logic [PosW-1:0]    bank_col [4];
   logic [PosW-1:0]    bank_row [4];
   logic [AddrW-1:0]   bank_addr [4];
   logic [3:0]         bank_we;
   logic [PixW-1:0]    bank_q [4];
   logic               load_ok;

   // Product stage.
   pwb_pkg::item_type     item2_ff;
   logic                  out2_ff;
   logic [2:0][ChanW-1:0] corner [4];
   logic [TermW-1:0]      term_ff [3][4];
   logic [TermW-1:0]      term_in [3][4];

   // Blend stage.
   logic [AccW-1:0]     acc [3];
   pwb_pkg::result_type result_ff, result_in;

   always_comb begin
      stage_en[Stages-1] = !valid_ff[Stages-1] || out_ready;
      for (int k = Stages - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in[0] = in_valid;
      valid_in[1] = valid_ff[0];
      valid_in[2] = valid_ff[1];
      valid_in[3] = valid_ff[2] && (item2_ff.op == pwb_pkg::OP_SAMPLE);
   end

   always_comb begin
      out0_in = in_data.outside || (in_data.quot_x > QuotW'(LimitX)) ||
                (in_data.quot_y > QuotW'(LimitY));
      x0_in   = in_data.quot_x[QuotW-1:FracW];
      y0_in   = in_data.quot_y[QuotW-1:FracW];
      x1_in   = x0_in + PosW'(in_data.quot_x[FracW-1:0] != '0);
      y1_in   = y0_in + PosW'(in_data.quot_y[FracW-1:0] != '0);
   end

   always_comb begin
      wx1 = {1'b0, fx_ff};
      wy1 = {1'b0, fy_ff};
      wx0 = FracOneW'(1 << FracW) - wx1;
      wy0 = FracOneW'(1 << FracW) - wy1;
      weight_in[0] = WeightW'(wx0 * wy0);
      weight_in[1] = WeightW'(wx1 * wy0);
      weight_in[2] = WeightW'(wx1 * wy1);
      weight_in[3] = WeightW'(wx0 * wy1);
      sel_in[0] = {y0_ff[0], x0_ff[0]};
      sel_in[1] = {y0_ff[0], x1_ff[0]};
      sel_in[2] = {y1_ff[0], x1_ff[0]};
      sel_in[3] = {y1_ff[0], x0_ff[0]};
      load_ok = (item0_ff.op == pwb_pkg::OP_LOAD) && (32'(item0_ff.col) < SRC_WIDTH) &&
                (32'(item0_ff.row) < SRC_HEIGHT);
      for (int b = 0; b < 4; b++) begin
         if (item0_ff.op == pwb_pkg::OP_LOAD) begin
            bank_col[b] = item0_ff.col;
            bank_row[b] = item0_ff.row;
         end else begin
            bank_col[b] = (b[0] == x0_ff[0]) ? x0_ff : x1_ff;
            bank_row[b] = (b[1] == y0_ff[0]) ? y0_ff : y1_ff;
         end
         bank_addr[b] = AddrW'((32'(bank_row[b]) >> 1) * HalfW + (32'(bank_col[b]) >> 1));
         bank_we[b]   = valid_ff[0] && stage_en[1] && load_ok &&
                        ({item0_ff.row[0], item0_ff.col[0]} == 2'(b));
      end
   end

   for (genvar b = 0; b < 4; b++) begin : g_bank
      pwb_ram #(
         .WIDTH (PixW),
         .DEPTH (BankDepth)
      ) u_bank (
         .clock   (clock),
         .wr_en   (bank_we[b]),
         .wr_addr (bank_addr[b]),
         .wr_data (item0_ff.pix),
         .rd_en   (stage_en[1]),
         .rd_addr (bank_addr[b]),
         .rd_data (bank_q[b])
      );
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         corner[k] = bank_q[sel_ff[k]];
         for (int c = 0; c < 3; c++) begin
            term_in[c][k] = TermW'(corner[k][c] * weight_ff[k]);
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         acc[c] = AccW'(term_ff[c][0]) + AccW'(term_ff[c][1]) +
                  AccW'(term_ff[c][2]) + AccW'(term_ff[c][3]);
      end
      result_in.item      = item2_ff;
      result_in.outside   = out2_ff;
      result_in.pix.red   = out2_ff ? '0 : acc[2][2*FracW +: ChanW];
      result_in.pix.green = out2_ff ? '0 : acc[1][2*FracW +: ChanW];
      result_in.pix.blue  = out2_ff ? '0 : acc[0][2*FracW +: ChanW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < Stages; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         item0_ff <= in_data.item;
         out0_ff  <= out0_in;
         x0_ff    <= x0_in;
         x1_ff    <= x1_in;
         y0_ff    <= y0_in;
         y1_ff    <= y1_in;
         fx_ff    <= in_data.quot_x[FracW-1:0];
         fy_ff    <= in_data.quot_y[FracW-1:0];
      end
      if (stage_en[1]) begin
         item1_ff  <= item0_ff;
         out1_ff   <= out0_ff;
         weight_ff <= weight_in;
         sel_ff    <= sel_in;
      end
      if (stage_en[2]) begin
         item2_ff <= item1_ff;
         out2_ff  <= out1_ff;
         term_ff  <= term_in;
      end
      if (stage_en[3]) begin
         result_ff <= result_in;
      end
   end

   assign in_ready  = stage_en[0];
   assign out_valid = valid_ff[Stages-1];
   assign out_data  = result_ff;

endmodule
`default_nettype wire

### rtl/perspective_warp_bilinear_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Perspective warp with bilinear sampling
// Load items fill the source image; sample items return warped pixels.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle unless the response side stalls the
// pipeline, and delivers one result per sample item in the order the items
// arrived; load items give no result. An item passes four mapping stages, one
// divider stage per quotient bit (ceil(log2((max(SRC_WIDTH, SRC_HEIGHT) - 1)
// * 256 + 1)) stages, 16 at the default size) and four sampling stages. The
// source image lives in four banks split by row and column parity, so the four
// neighbors of a sample are read in the same cycle. Coefficients must be
// written only while idle; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module perspective_warp_bilinear_unit #(
   parameter int SRC_WIDTH  = pwb_pkg::SrcWidthDefault,
   parameter int SRC_HEIGHT = pwb_pkg::SrcHeightDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   pwb_req_if.sink                    req_ch,
   pwb_rsp_if.source                  rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [2:0]                 csr_index,
   input  logic [pwb_pkg::CoefW-1:0]  csr_wdata
);

   localparam int MaxDim   = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
   localparam int QuotBits = $clog2((MaxDim - 1) * (1 << pwb_pkg::FracW) + 1);

   pwb_pkg::coef_set_type coef_ff, coef_in;
   pwb_pkg::item_type     req_item;
   pwb_pkg::div_type      div_data [QuotBits+1];
   logic [QuotBits:0]     div_valid;
   logic [QuotBits:0]     div_ready;
   pwb_pkg::result_type   result;

   always_comb begin
      coef_in = coef_ff;
      if (csr_wr_en) begin
         coef_in[csr_index] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= pwb_pkg::CoefReset;
      end else begin
         coef_ff <= coef_in;
      end
   end

   always_comb begin
      req_item.op        = pwb_pkg::op_type'(req_ch.op);
      req_item.col       = req_ch.col;
      req_item.row       = req_ch.row;
      req_item.pix.red   = req_ch.red;
      req_item.pix.green = req_ch.green;
      req_item.pix.blue  = req_ch.blue;
   end

   pwb_map #(
      .QUOT_BITS (QuotBits)
   ) u_map (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef_ff),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_item   (req_item),
      .out_valid (div_valid[0]),
      .out_ready (div_ready[0]),
      .out_data  (div_data[0])
   );

   for (genvar k = 0; k < QuotBits; k++) begin : g_div
      pwb_div_stage #(
         .SHIFT (QuotBits - 1 - k)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[k]),
         .in_ready  (div_ready[k]),
         .in_data   (div_data[k]),
         .out_valid (div_valid[k+1]),
         .out_ready (div_ready[k+1]),
         .out_data  (div_data[k+1])
      );
   end

   pwb_sampler #(
      .SRC_WIDTH  (SRC_WIDTH),
      .SRC_HEIGHT (SRC_HEIGHT)
   ) u_sampler (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid[QuotBits]),
      .in_ready  (div_ready[QuotBits]),
      .in_data   (div_data[QuotBits]),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (result)
   );

   assign rsp_ch.out_col   = result.item.col;
   assign rsp_ch.out_row   = result.item.row;
   assign rsp_ch.out_red   = result.pix.red;
   assign rsp_ch.out_green = result.pix.green;
   assign rsp_ch.out_blue  = result.pix.blue;
   assign rsp_ch.outside   = result.outside;

   // An outside sample is always black.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.outside |->
         rsp_ch.out_red == '0 && rsp_ch.out_green == '0 && rsp_ch.out_blue == '0)
      else $error("outside sample carries color");

   // A ready response side lets the whole pipeline advance.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.ready |-> req_ch.ready)
      else $error("request stalled while response side is ready");

   // A register write lands in the addressed coefficient.
   assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> coef_ff[$past(csr_index)] == $past(csr_wdata))
      else $error("coefficient write lost");

   // Reset restores the identity mapping.
   assert property (@(posedge clock)
      $past(reset) |-> coef_ff == pwb_pkg::CoefReset)
      else $error("coefficients not restored by reset");

endmodule
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Perspective warp unit testbench
// Loads a source image, writes several homographies and checks every sampled
// pixel against a behavioral warp predictor, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int SrcW = 256;
   localparam int SrcH = 256;
   localparam int Latency = 40;
   localparam int FillSize = 24;

   typedef struct {
      logic [pwb_pkg::PosW-1:0]  col;
      logic [pwb_pkg::PosW-1:0]  row;
      logic [pwb_pkg::ChanW-1:0] red;
      logic [pwb_pkg::ChanW-1:0] green;
      logic [pwb_pkg::ChanW-1:0] blue;
      logic                      outside;
   } warp_pixel_type;

   typedef struct {
      pwb_pkg::op_type          op;
      logic [pwb_pkg::PosW-1:0] col;
      logic [pwb_pkg::PosW-1:0] row;
      logic [23:0]              rgb;
      bit                       typed;
      logic                     outside;
      logic [23:0]              expect_rgb;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [pwb_pkg::CoefW-1:0] csr_wdata = '0;

   pwb_req_if req_ch ();
   pwb_rsp_if rsp_ch ();

   perspective_warp_bilinear_unit uut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   logic [23:0] image_copy [SrcW*SrcH];
   bit          image_loaded [SrcW*SrcH];
   logic signed [pwb_pkg::CoefW-1:0] homography [pwb_pkg::NumCoef];
   warp_pixel_type pending_pixels [$];
   int error_count = 0;
   int sample_count = 0;
   int load_count = 0;
   int outside_count = 0;
   bit hold_off = 1'b0;
   bit rsp_stall_mode = 1'b0;

   function automatic longint floor_quot(longint n, longint d);
      longint q;
      longint r;
      q = n / d;
      r = n % d;
      if (r != 0 && ((r < 0) != (d < 0))) q -= 1;
      return q;
   endfunction

   // Maps an output pixel through the homography and reports the source point.
   function automatic bit map_point(int c, int r, output longint u, output longint v);
      longint sx;
      longint sy;
      longint sw;
      sx = longint'(homography[0]) * c + longint'(homography[1]) * r + homography[2];
      sy = longint'(homography[3]) * c + longint'(homography[4]) * r + homography[5];
      sw = longint'(homography[6]) * c + longint'(homography[7]) * r + 65536;
      u = -1;
      v = -1;
      if (sw == 0) return 1'b0;
      u = floor_quot(sx * 256, sw);
      v = floor_quot(sy * 256, sw);
      return !(u < 0 || u > (SrcW - 1) * 256 || v < 0 || v > (SrcH - 1) * 256);
   endfunction

   function automatic warp_pixel_type warp_sample(logic [pwb_pkg::PosW-1:0] c,
                                                  logic [pwb_pkg::PosW-1:0] r);
      warp_pixel_type p;
      longint u;
      longint v;
      int x0, y0, x1, y1, fx, fy;
      logic [23:0] pa, pb, pc, pd;
      longint s;
      p.col = c;
      p.row = r;
      p.red = '0;
      p.green = '0;
      p.blue = '0;
      p.outside = 1'b1;
      if (!map_point(c, r, u, v)) return p;
      x0 = int'(u >> 8);
      y0 = int'(v >> 8);
      fx = int'(u & 255);
      fy = int'(v & 255);
      x1 = fx != 0 ? x0 + 1 : x0;
      y1 = fy != 0 ? y0 + 1 : y0;
      pa = image_copy[y0*SrcW + x0];
      pb = image_copy[y0*SrcW + x1];
      pc = image_copy[y1*SrcW + x1];
      pd = image_copy[y1*SrcW + x0];
      for (int k = 0; k < 3; k++) begin
         int sh;
         sh = 16 - 8 * k;
         s = longint'((pa >> sh) & 8'hff) * (256 - fx) * (256 - fy)
           + longint'((pb >> sh) & 8'hff) * fx * (256 - fy)
           + longint'((pc >> sh) & 8'hff) * fx * fy
           + longint'((pd >> sh) & 8'hff) * (256 - fx) * fy;
         case (k)
            0: p.red = 8'((s >> 16) & 255);
            1: p.green = 8'((s >> 16) & 255);
            default: p.blue = 8'((s >> 16) & 255);
         endcase
      end
      p.outside = 1'b0;
      return p;
   endfunction

   // A sample is safe only when every neighbor it would read has been loaded.
   function automatic bit sample_is_safe(logic [pwb_pkg::PosW-1:0] c,
                                         logic [pwb_pkg::PosW-1:0] r);
      longint u;
      longint v;
      int x0, y0, x1, y1;
      if (!map_point(c, r, u, v)) return 1'b1;
      x0 = int'(u >> 8);
      y0 = int'(v >> 8);
      x1 = (u & 255) != 0 ? x0 + 1 : x0;
      y1 = (v & 255) != 0 ? y0 + 1 : y0;
      return image_loaded[y0*SrcW+x0] && image_loaded[y0*SrcW+x1] &&
             image_loaded[y1*SrcW+x1] && image_loaded[y1*SrcW+x0];
   endfunction

   task automatic send_item(pwb_pkg::op_type op, logic [pwb_pkg::PosW-1:0] c,
                            logic [pwb_pkg::PosW-1:0] r,
                            logic [23:0] rgb, bit typed = 1'b0,
                            logic t_out = 1'b0, logic [23:0] t_rgb = '0);
      warp_pixel_type p;
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.col <= c;
      req_ch.row <= r;
      req_ch.red <= rgb[23:16];
      req_ch.green <= rgb[15:8];
      req_ch.blue <= rgb[7:0];
      do @(posedge clock); while (!req_ch.ready);
      if (op == pwb_pkg::OP_LOAD) begin
         load_count++;
         if (c < SrcW && r < SrcH) begin
            image_copy[r*SrcW + c] = rgb;
            image_loaded[r*SrcW + c] = 1'b1;
         end
      end else begin
         p = warp_sample(c, r);
         if (typed && (p.outside !== t_out || {p.red, p.green, p.blue} !== t_rgb)) begin
            $display("%0t: directed row at (%0d,%0d) expected out %b rgb %h, ",
                     $time, c, r, t_out, t_rgb,
                     "predictor gives out %b rgb %h", p.outside,
                     {p.red, p.green, p.blue});
            error_count++;
         end
         pending_pixels = {pending_pixels, p};
         sample_count++;
      end
   endtask

   task automatic go_idle(int cycles);
      req_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (Latency) @(posedge clock);
   endtask

   task automatic write_coef(pwb_pkg::reg_type idx, logic [pwb_pkg::CoefW-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      homography[idx] = value;
   endtask

   task automatic write_homography(logic [pwb_pkg::CoefW-1:0] a, b, c, d, e, f, g, h);
      write_coef(pwb_pkg::REG_COEF_A, a);
      write_coef(pwb_pkg::REG_COEF_B, b);
      write_coef(pwb_pkg::REG_COEF_C, c);
      write_coef(pwb_pkg::REG_COEF_D, d);
      write_coef(pwb_pkg::REG_COEF_E, e);
      write_coef(pwb_pkg::REG_COEF_F, f);
      write_coef(pwb_pkg::REG_COEF_G, g);
      write_coef(pwb_pkg::REG_COEF_H, h);
   endtask

   function automatic logic [pwb_pkg::PosW-1:0] rand_pos();
      case ($urandom_range(0, 5))
         0: return pwb_pkg::PosW'($urandom);
         1: return pwb_pkg::PosW'($urandom_range(0, 3));
         default: return pwb_pkg::PosW'($urandom_range(0, FillSize + 3));
      endcase
   endfunction

   task automatic random_phase(int count);
      int burst;
      logic [pwb_pkg::PosW-1:0] c;
      logic [pwb_pkg::PosW-1:0] r;
      burst = $urandom_range(1, 20);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 4) == 0) begin
            send_item(pwb_pkg::OP_LOAD, rand_pos(), rand_pos(), 24'($urandom));
         end else begin
            c = rand_pos();
            r = rand_pos();
            while (!sample_is_safe(c, r)) begin
               c = rand_pos();
               r = rand_pos();
            end
            send_item(pwb_pkg::OP_SAMPLE, c, r, 24'($urandom));
         end
         if (--burst == 0) begin
            if ($urandom_range(0, 1) == 1) go_idle($urandom_range(1, 6));
            burst = $urandom_range(1, 20);
         end
      end
   endtask

   stim_row_type directed_rows [] = '{
      '{pwb_pkg::OP_SAMPLE, 12'd0, 12'd0, 24'h0, 1'b1, 1'b0, 24'h123456},
      '{pwb_pkg::OP_SAMPLE, 12'd255, 12'd255, 24'h0, 1'b1, 1'b0, 24'hfe01ff},
      '{pwb_pkg::OP_SAMPLE, 12'd256, 12'd0, 24'hffffff, 1'b1, 1'b1, 24'h0},
      '{pwb_pkg::OP_SAMPLE, 12'd0, 12'd256, 24'h0, 1'b1, 1'b1, 24'h0},
      '{pwb_pkg::OP_SAMPLE, 12'd4095, 12'd4095, 24'h0, 1'b1, 1'b1, 24'h0},
      '{pwb_pkg::OP_LOAD, 12'd4095, 12'd0, 24'hffffff, 1'b0, 1'b0, 24'h0},
      '{pwb_pkg::OP_LOAD, 12'd0, 12'd256, 24'hffffff, 1'b0, 1'b0, 24'h0},
      '{pwb_pkg::OP_SAMPLE, 12'd0, 12'd0, 24'h0, 1'b1, 1'b0, 24'h123456},
      '{pwb_pkg::OP_SAMPLE, 12'd17, 12'd200, 24'h0, 1'b0, 1'b0, 24'h0}
   };

   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected result (%0d,%0d)", $time,
                     rsp_ch.out_col, rsp_ch.out_row);
            error_count++;
         end else begin
            warp_pixel_type e;
            e = pending_pixels.pop_front();
            if (rsp_ch.out_col !== e.col || rsp_ch.out_row !== e.row ||
                rsp_ch.out_red !== e.red || rsp_ch.out_green !== e.green ||
                rsp_ch.out_blue !== e.blue || rsp_ch.outside !== e.outside) begin
               $display("%0t: expected col %0d row %0d rgb %h%h%h out %b, ",
                        $time, e.col, e.row, e.red, e.green, e.blue, e.outside,
                        "got col %0d row %0d rgb %h%h%h out %b",
                        rsp_ch.out_col, rsp_ch.out_row, rsp_ch.out_red,
                        rsp_ch.out_green, rsp_ch.out_blue, rsp_ch.outside);
               error_count++;
            end
            if (e.outside) outside_count++;
         end
      end
   end

   // The receiver stalls on a pattern of its own, or holds off completely.
   always @(posedge clock) begin
      if (reset || hold_off) rsp_ch.ready <= 1'b0;
      else if (rsp_stall_mode) rsp_ch.ready <= ($urandom_range(0, 2) != 0);
      else rsp_ch.ready <= 1'b1;
   end

   initial begin
      int phase_cycles;
      phase_cycles = 0;
      repeat (200) begin
         phase_cycles = $urandom_range(20, 200);
         repeat (phase_cycles) @(posedge clock);
         rsp_stall_mode <= !rsp_stall_mode;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.op = pwb_pkg::OP_LOAD;
      req_ch.col = '0;
      req_ch.row = '0;
      req_ch.red = '0;
      req_ch.green = '0;
      req_ch.blue = '0;
      for (int i = 0; i < pwb_pkg::NumCoef; i++) homography[i] = pwb_pkg::CoefReset[i];
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Corners and a pixel used by the directed samples, and a small block of the image.
      send_item(pwb_pkg::OP_LOAD, 12'd0, 12'd0, 24'h123456);
      send_item(pwb_pkg::OP_LOAD, 12'd255, 12'd255, 24'hfe01ff);
      for (int y = 16; y < 20; y++)
         for (int x = 16; x < 20; x++)
            send_item(pwb_pkg::OP_LOAD, pwb_pkg::PosW'(x), pwb_pkg::PosW'(y),
                      24'($urandom));
      send_item(pwb_pkg::OP_LOAD, 12'd17, 12'd200, 24'($urandom));
      foreach (directed_rows[i])
         send_item(directed_rows[i].op, directed_rows[i].col, directed_rows[i].row,
                   directed_rows[i].rgb, directed_rows[i].typed,
                   directed_rows[i].outside, directed_rows[i].expect_rgb);

      // A half pixel shift in x and a quarter pixel shift in y give fractional weights on the loaded block.
      drain_results();
      write_homography(32'h0001_0000, 0, 32'h0000_8000, 0, 32'h0001_0000,
                       32'h0000_4000, 0, 0);
      for (int y = 16; y < 19; y++)
         for (int x = 16; x < 19; x++)
            send_item(pwb_pkg::OP_SAMPLE, pwb_pkg::PosW'(x), pwb_pkg::PosW'(y), '0);
      drain_results();

      // Fill the block of the image where most random samples land.
      write_homography(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 0, 0);
      for (int y = 0; y < FillSize; y++)
         for (int x = 0; x < FillSize; x++)
            send_item(pwb_pkg::OP_LOAD, pwb_pkg::PosW'(x), pwb_pkg::PosW'(y),
                      24'($urandom));

      // Zero divisor and extreme coefficients.
      drain_results();
      write_homography(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                       32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000, 0);
      send_item(pwb_pkg::OP_SAMPLE, 12'd1, 12'd0, '0);
      send_item(pwb_pkg::OP_SAMPLE, 12'd0, 12'd0, '0);
      send_item(pwb_pkg::OP_SAMPLE, 12'd4095, 12'd4095, '0);
      drain_results();

      // Random phases under several homographies.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: write_homography(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 0, 0);
            1: write_homography(32'h0000_c000, 32'h0000_2000, 32'h0002_8000,
                                32'hffff_e000, 32'h0000_e000, 32'h0004_0000, 0, 0);
            2: write_homography(32'h0000_8000, 0, 0, 0, 32'h0000_8000, 0,
                                32'h0000_0040, 32'h0000_0020);
            3: write_homography(32'hffff_0000, 0, 32'h00ff_0000, 0,
                                32'hffff_0000, 32'h00ff_0000, 0, 0);
            4: write_homography($urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom);
            default: write_homography(32'h0000_4000 + $urandom_range(0, 65535),
                                      32'($urandom_range(0, 8191)),
                                      32'($urandom_range(0, 1 << 22)),
                                      32'($urandom_range(0, 8191)),
                                      32'h0000_4000 + $urandom_range(0, 65535),
                                      32'($urandom_range(0, 1 << 22)),
                                      32'($urandom_range(0, 255)),
                                      32'($urandom_range(0, 255)));
         endcase
         random_phase(ph == 4 ? 100 : 130);
         if (ph == 2) begin
            hold_off <= 1'b1;
            fork
               begin
                  repeat (300) @(posedge clock);
                  hold_off <= 1'b0;
               end
               random_phase(60);
            join
         end
         drain_results();
      end

      $display("Covered %0d loads and %0d samples, %0d of them outside the image.",
               load_count, sample_count, outside_count);
      if (error_count == 0) $display("perspective_warp_bilinear_unit test passed");
      else $display("perspective_warp_bilinear_unit test failed");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("perspective_warp_bilinear_unit test failed");
      $finish;
   end
endmodule
